FILE: rtl/mandelbrot_escape_time_pixel_core_macros.svh
// Assertion helpers shared by the RTL of the escape-time pixel core.
// Each macro builds one labeled concurrent assertion that is disabled while
// the synchronous active-low reset is asserted.
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_CORE_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define METS_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define METS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/mets_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mets_pkg;

    // Fixed-point format of the complex plane coordinates, and width of the pixel coordinates.
    localparam int FRAC_BITS  = 28;
    localparam int COORD_BITS = 12;

    // Field width of the escape counts in the result items.
    localparam int COUNT_W = 16;

    // Shared multiplier: signed operands and full-width products.
    localparam int MUL_LANES = 3;
    localparam int MOP_W     = 37;
    localparam int PROD_W    = 2 * MOP_W;
    localparam int Q_W       = PROD_W - FRAC_BITS;

    typedef logic signed [MOP_W-1:0]  t_mop;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [Q_W-1:0]    t_q;

    // Constants of the cardioid and bulb tests.
    localparam t_mop M_QUARTER   = t_mop'(64'd1 << (FRAC_BITS - 2));
    localparam t_mop M_ONE       = t_mop'(64'd1 << FRAC_BITS);
    localparam t_q   Q_SIXTEENTH = t_q'(64'd1 << (FRAC_BITS - 4));

    // Iteration limits above this value enable the shortcut tests.
    localparam logic [COUNT_W-1:0] SHORTCUT_THRESHOLD = 16'd10;

    // Configuration port geometry.
    localparam int CFG_DW = 64;
    localparam int CFG_AW = 6;
    localparam int REG_IDX_W = 3;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_MAX_ITER = 3'd0,
        REG_BAILOUT  = 3'd1,
        REG_X_STEP   = 3'd2,
        REG_Y_STEP   = 3'd3,
        REG_X_OFFSET = 3'd4,
        REG_Y_OFFSET = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [15:0]        max_iter;
        logic [33:0]        bailout;
        logic [30:0]        x_step;
        logic [30:0]        y_step;
        logic signed [31:0] x_offset;
        logic signed [31:0] y_offset;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        max_iter: 16'd256,
        bailout:  34'd1073741824,
        x_step:   31'd1048576,
        y_step:   31'd1048576,
        x_offset: 32'sd536870912,
        y_offset: 32'sd536870912
    };

    // Sequencer states of the pixel core.
    typedef enum logic [3:0] {
        S_IDLE,
        S_COORD,
        S_CSET,
        S_SC_PREP,
        S_SC_SQ,
        S_SC_SUM,
        S_SC_MUL,
        S_SC_TEST,
        S_IMUL,
        S_ISTEP,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

FILE: rtl/mets_pix_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Pixel request channel.
interface mets_pix_if import mets_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_row;
    logic [COORD_BITS-1:0] pixel_col;
    logic                  frame_start;

    modport source (output valid, output pixel_row, output pixel_col,
                    output frame_start, input ready);
    modport sink   (input valid, input pixel_row, input pixel_col,
                    input frame_start, output ready);
endinterface

`default_nettype wire

FILE: rtl/mets_res_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Escape-time result channel.
interface mets_res_if import mets_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] escape_count;
    logic               is_inside;
    logic [COUNT_W-1:0] min_escape;
    logic [COUNT_W-1:0] max_escape;

    modport source (output valid, output escape_count, output is_inside,
                    output min_escape, output max_escape, input ready);
    modport sink   (input valid, input escape_count, input is_inside,
                    input min_escape, input max_escape, output ready);
endinterface

`default_nettype wire

FILE: rtl/mets_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
`include "mandelbrot_escape_time_pixel_core_macros.svh"

module mets_cfg import mets_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg                 r_cfg;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    // Registers sit on 8-byte boundaries; the low address bits are ignored.
    assign reg_idx = paddr[CFG_AW-1:3];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    // Register writes, truncated to each register's width.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_MAX_ITER: r_cfg.max_iter <= pwdata[15:0];
                REG_BAILOUT:  r_cfg.bailout  <= pwdata[33:0];
                REG_X_STEP:   r_cfg.x_step   <= pwdata[30:0];
                REG_Y_STEP:   r_cfg.y_step   <= pwdata[30:0];
                REG_X_OFFSET: r_cfg.x_offset <= pwdata[31:0];
                REG_Y_OFFSET: r_cfg.y_offset <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    // Read-back multiplexer.
    always_comb begin
        unique case (reg_idx)
            REG_MAX_ITER: prdata = {48'd0, r_cfg.max_iter};
            REG_BAILOUT:  prdata = {30'd0, r_cfg.bailout};
            REG_X_STEP:   prdata = {33'd0, r_cfg.x_step};
            REG_Y_STEP:   prdata = {33'd0, r_cfg.y_step};
            REG_X_OFFSET: prdata = {32'd0, r_cfg.x_offset};
            REG_Y_OFFSET: prdata = {32'd0, r_cfg.y_offset};
            default:      prdata = '0;
        endcase
    end

    // A write to the iteration limit lands in the register in the next cycle.
    `METS_ASSERT_NEXT(a_max_iter_write, i_clk, i_rst_n, wr_en && (reg_idx == REG_MAX_ITER), r_cfg.max_iter == $past(pwdata[15:0]), "iteration limit write lost")

endmodule

`default_nettype wire

FILE: rtl/mets_mul3.sv
`timescale 1ns / 1ps
`default_nettype none

// Shared three-lane signed multiplier with registered products. The
// sequencer feeds it the squares and cross product of z, the coordinate
// scaling, and the products of the cardioid and bulb tests.
module mets_mul3 import mets_pkg::*; (
    input  logic  i_clk,
    input  logic  i_en,
    input  t_mop  i_a [MUL_LANES],
    input  t_mop  i_b [MUL_LANES],
    output t_prod o_p [MUL_LANES]
);

    t_prod r_p [MUL_LANES];

    // One full-precision product per lane per cycle while enabled.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < MUL_LANES; l++) begin
                r_p[l] <= i_a[l] * i_b[l];
            end
        end
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

FILE: rtl/mandelbrot_escape_time_pixel_core.sv
// Escape-time engine for one pixel at a time.
// Pixel items arrive on i_pix (row, column, frame_start) under a valid/ready
// handshake; one result item per pixel leaves on o_res (escape count, inside
// flag, and the running minimum and maximum escape counts of the frame).
// The registers are written through the APB port at byte address 8*index.
// A pixel is accepted only while the core is idle. It goes through the
// coordinate mapping, then the cardioid and bulb tests when the iteration
// limit exceeds 10, then the iterations of z = z^2 + c on the shared
// three-lane multiplier (a multiply state and a step state each), and last
// the hand-over of the result. A shortcut hit skips the iterations. After
// the hand-over the core returns to idle to take the next pixel.
// The result register decouples the two sides: the next pixel is taken while
// a finished result still waits. When the receiver stalls with a result
// pending, the following pixel finishes its work and then holds in the
// hand-over state until the result register frees up.
// Reset clears the registers to their defaults, empties the result register
// and resets the frame statistics (minimum all ones, maximum zero).
`timescale 1ns / 1ps
`default_nettype none
`include "mandelbrot_escape_time_pixel_core_macros.svh"

module mandelbrot_escape_time_pixel_core import mets_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mets_pix_if.sink          i_pix,
    mets_res_if.source        o_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready
);

    localparam int SW = Q_W + 1;

    // Floor of a product scaled back to the fixed-point format.
    function automatic t_q mulq(input t_prod p);
        return t_q'(p >>> FRAC_BITS);
    endfunction

    // Saturate a wide sum to a signed 32-bit coordinate.
    function automatic logic signed [31:0] sat32(input logic signed [SW-1:0] v);
        logic [SW-32:0] hi;
        hi = v[SW-1:31];
        if ((&hi) || !(|hi)) begin
            return v[31:0];
        end else if (v[SW-1]) begin
            return 32'sh8000_0000;
        end else begin
            return 32'sh7fff_ffff;
        end
    endfunction

    t_cfg                   cfg_q;
    t_state                 r_state;
    t_state                 n_state;

    logic [COORD_BITS-1:0]  r_row;
    logic [COORD_BITS-1:0]  r_col;
    logic signed [31:0]     r_cr;
    logic signed [31:0]     r_ci;
    logic signed [31:0]     r_zr;
    logic signed [31:0]     r_zi;
    logic [COUNT_W-1:0]     r_iter;
    t_mop                   r_xp;
    t_mop                   r_bp;
    t_q                     r_ysq;
    t_q                     r_q;
    t_q                     r_s;
    logic                   r_bulb;
    logic                   r_inside;
    logic [COUNT_W-1:0]     r_count;
    logic [COUNT_W-1:0]     r_frame_min;
    logic [COUNT_W-1:0]     r_frame_max;
    logic [COUNT_W-1:0]     n_frame_min;
    logic [COUNT_W-1:0]     n_frame_max;

    logic                   r_out_valid;
    logic [COUNT_W-1:0]     r_out_count;
    logic                   r_out_inside;
    logic [COUNT_W-1:0]     r_out_min;
    logic [COUNT_W-1:0]     r_out_max;

    logic                   pix_ready;
    logic                   pix_acc;
    logic                   out_free;
    logic                   out_load;
    logic                   mul_en;
    t_mop                   mul_a [MUL_LANES];
    t_mop                   mul_b [MUL_LANES];
    t_prod                  mul_p [MUL_LANES];

    t_q                     q0;
    t_q                     q1;
    t_q                     q2;
    logic signed [SW-1:0]   cr_sum;
    logic signed [SW-1:0]   ci_sum;
    logic signed [SW-1:0]   nr_sum;
    logic signed [SW-1:0]   ni_sum;
    logic signed [SW-1:0]   mag2;
    logic signed [SW-1:0]   bail_x;
    logic signed [31:0]     nr;
    logic signed [31:0]     ni;
    logic                   escaped;
    logic                   limit_hit;
    logic                   fixed_pt;
    logic                   shortcut_hit;

    mets_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg_q)
    );

    mets_mul3 u_mul (
        .i_clk (i_clk),
        .i_en  (mul_en),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    // Handshake terms.
    assign pix_acc  = i_pix.valid && pix_ready;
    assign out_free = !r_out_valid || o_res.ready;

    // Arithmetic on the registered products.
    always_comb begin
        q0      = mulq(mul_p[0]);
        q1      = mulq(mul_p[1]);
        q2      = mulq(mul_p[2]);
        cr_sum  = mul_p[0][SW-1:0] - SW'(cfg_q.x_offset);
        ci_sum  = mul_p[1][SW-1:0] - SW'(cfg_q.y_offset);
        nr_sum  = SW'(q0) - SW'(q1) + SW'(r_cr);
        ni_sum  = (SW'(q2) <<< 1) + SW'(r_ci);
        nr      = sat32(nr_sum);
        ni      = sat32(ni_sum);
        // The squares of the current z give the bailout test of the step
        // that produced it.
        mag2    = SW'(q0) + SW'(q1);
        bail_x  = SW'(cfg_q.bailout);
        escaped   = (r_iter != '0) && (mag2 > bail_x);
        limit_hit = (r_iter == cfg_q.max_iter);
        fixed_pt  = (nr == r_zr) && (ni == r_zi);
        shortcut_hit = (q0 < (r_ysq >>> 2)) || r_bulb;
        n_frame_min = (!r_inside && (r_count < r_frame_min)) ? r_count : r_frame_min;
        n_frame_max = (!r_inside && (r_count > r_frame_max)) ? r_count : r_frame_max;
    end

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (pix_acc) n_state = S_COORD;
            S_COORD:   n_state = S_CSET;
            S_CSET:    n_state = (cfg_q.max_iter > SHORTCUT_THRESHOLD) ? S_SC_PREP : S_IMUL;
            S_SC_PREP: n_state = S_SC_SQ;
            S_SC_SQ:   n_state = S_SC_SUM;
            S_SC_SUM:  n_state = S_SC_MUL;
            S_SC_MUL:  n_state = S_SC_TEST;
            S_SC_TEST: n_state = shortcut_hit ? S_OUT : S_IMUL;
            S_IMUL:    n_state = S_ISTEP;
            S_ISTEP:   n_state = (escaped || limit_hit || fixed_pt) ? S_OUT : S_IMUL;
            S_OUT:     if (out_free) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs: handshake and multiplier operand selection.
    always_comb begin
        pix_ready = 1'b0;
        out_load  = 1'b0;
        mul_en    = 1'b0;
        for (int l = 0; l < MUL_LANES; l++) begin
            mul_a[l] = '0;
            mul_b[l] = '0;
        end
        unique case (r_state)
            S_IDLE: begin
                pix_ready = 1'b1;
            end
            S_COORD: begin
                mul_en   = 1'b1;
                mul_a[0] = t_mop'(r_col);
                mul_b[0] = t_mop'(cfg_q.x_step);
                mul_a[1] = t_mop'(r_row);
                mul_b[1] = t_mop'(cfg_q.y_step);
            end
            S_SC_SQ: begin
                mul_en   = 1'b1;
                mul_a[0] = t_mop'(r_ci);
                mul_b[0] = t_mop'(r_ci);
                mul_a[1] = r_xp;
                mul_b[1] = r_xp;
                mul_a[2] = r_bp;
                mul_b[2] = r_bp;
            end
            S_SC_MUL: begin
                mul_en   = 1'b1;
                mul_a[0] = signed'(r_q[MOP_W-1:0]);
                mul_b[0] = signed'(r_s[MOP_W-1:0]);
            end
            S_IMUL: begin
                mul_en   = 1'b1;
                mul_a[0] = t_mop'(r_zr);
                mul_b[0] = t_mop'(r_zr);
                mul_a[1] = t_mop'(r_zi);
                mul_b[1] = t_mop'(r_zi);
                mul_a[2] = t_mop'(r_zr);
                mul_b[2] = t_mop'(r_zi);
            end
            S_OUT: begin
                out_load = out_free;
            end
            default: ;
        endcase
    end

    // Control state, result valid flag and frame statistics.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_frame_min <= '1;
            r_frame_max <= '0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
                r_frame_min <= n_frame_min;
                r_frame_max <= n_frame_max;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (pix_acc && i_pix.frame_start) begin
                r_frame_min <= '1;
                r_frame_max <= '0;
            end
        end
    end

    // Datapath registers, stepped by the sequencer.
    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            r_row <= i_pix.pixel_row;
            r_col <= i_pix.pixel_col;
        end
        case (r_state)
            S_CSET: begin
                r_cr   <= sat32(cr_sum);
                r_ci   <= sat32(ci_sum);
                r_zr   <= '0;
                r_zi   <= '0;
                r_iter <= '0;
            end
            S_SC_PREP: begin
                r_xp <= t_mop'(r_cr) - M_QUARTER;
                r_bp <= t_mop'(r_cr) + M_ONE;
            end
            S_SC_SUM: begin
                r_ysq  <= q0;
                r_q    <= q1 + q0;
                r_s    <= q1 + q0 + t_q'(r_xp);
                r_bulb <= (q2 + q0) < Q_SIXTEENTH;
            end
            S_SC_TEST: begin
                r_inside <= 1'b1;
                r_count  <= '0;
            end
            S_ISTEP: begin
                if (escaped) begin
                    r_inside <= 1'b0;
                    r_count  <= r_iter - 16'd1;
                end else begin
                    r_inside <= 1'b1;
                    r_count  <= '0;
                    r_zr     <= nr;
                    r_zi     <= ni;
                    r_iter   <= r_iter + 16'd1;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    r_out_count  <= r_count;
                    r_out_inside <= r_inside;
                    r_out_min    <= n_frame_min;
                    r_out_max    <= n_frame_max;
                end
            end
            default: ;
        endcase
    end

    // Channel outputs.
    assign i_pix.ready        = pix_ready;
    assign o_res.valid        = r_out_valid;
    assign o_res.escape_count = r_out_count;
    assign o_res.is_inside    = r_out_inside;
    assign o_res.min_escape   = r_out_min;
    assign o_res.max_escape   = r_out_max;

    // An accepted pixel starts the coordinate mapping at once.
    `METS_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, i_pix.valid && i_pix.ready, r_state == S_COORD, "accepted item did not start")
    // A new result only appears out of the hand-over state.
    `METS_ASSERT_SAME(a_result_source, i_clk, i_rst_n, $rose(o_res.valid), $past(r_state == S_OUT), "result loaded outside hand-over")
    // A stalled receiver holds the finished pixel in the hand-over state.
    `METS_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, (r_state == S_OUT) && o_res.valid && !o_res.ready, r_state == S_OUT, "finished item left while result pending")
    // An escaped pixel lies within the frame statistics it reports.
    `METS_ASSERT_SAME(a_stats_bound, i_clk, i_rst_n, o_res.valid && !o_res.is_inside, (o_res.min_escape <= o_res.escape_count) && (o_res.max_escape >= o_res.escape_count), "frame statistics exclude escape count")

endmodule

`default_nettype wire
